// ----- rtl/npc_pkg.sv -----
// shared types and codes of the no-data aware pixel compositor
// no dependencies; imported by every module of the block
package npc_pkg;

  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_FIRST = 3'd1;
  localparam logic [2:0] MODE_LAST  = 3'd2;
  localparam logic [2:0] MODE_MIN   = 3'd3;
  localparam logic [2:0] MODE_MAX   = 3'd4;
  localparam logic [2:0] MODE_MEAN  = 3'd5;

  localparam logic KIND_FOLD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_PPI   = 2'd1;
  localparam logic [1:0] REG_TIMES = 2'd2;

  localparam int ACC_W = 48;
  localparam int CNT_W = 16;
  localparam int VAL_W = 32;

  // one queued transaction, already range checked
  typedef struct packed {
    logic              kind;
    logic [1:0]        band;
    logic [1:0]        time_slot;
    logic [9:0]        pixel;
    logic [VAL_W-1:0]  pixel_value;
    logic              pixel_present;
    logic              in_range;
  } item_t;

endpackage

// ----- rtl/npc_front.sv -----
// front end: accepts transactions, checks the cell range, queues them
// depends on npc_pkg
module npc_front #(
  parameter int BANDS       = 4,
  parameter int TIME_SLOTS  = 4,
  parameter int TILE_PIXELS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 kind,
  input  logic [1:0]           band,
  input  logic [1:0]           time_slot,
  input  logic [9:0]           pixel,
  input  logic [31:0]          pixel_value,
  input  logic                 pixel_present,
  input  logic [10:0]          pixels_per_image,
  input  logic [2:0]           times_per_chunk,
  input  logic                 pop,
  output npc_pkg::item_t       head,
  output logic                 head_valid,
  output logic                 full
);
  import npc_pkg::*;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       in_range;
  item_t      entry;

  always_comb begin
    in_range = (32'(band) < BANDS) && (32'(time_slot) < TIME_SLOTS) &&
               ({1'b0, time_slot} < times_per_chunk) &&
               (32'(pixel) < TILE_PIXELS) && ({1'b0, pixel} < pixels_per_image);
    entry.kind          = kind;
    entry.band          = band;
    entry.time_slot     = time_slot;
    entry.pixel         = pixel;
    entry.pixel_value   = pixel_value;
    entry.pixel_present = pixel_present;
    entry.in_range      = in_range;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (accept) wr_ptr <= ~wr_ptr;
      if (pop)    rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(accept) - 2'(pop);
    end
  end

  assign head       = q[rd_ptr];
  assign head_valid = (fill != 2'd0);
  assign full       = (fill == 2'd2);

endmodule

// ----- rtl/npc_div.sv -----
// iterative unsigned divider, one quotient bit per cycle
// depends on npc_pkg
module npc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [npc_pkg::ACC_W-1:0]  dividend,
  input  logic [npc_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [npc_pkg::ACC_W-1:0]  quotient
);
  import npc_pkg::*;

  localparam int STEP_W = $clog2(ACC_W);

  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  den;
  logic [STEP_W-1:0] step;
  logic              running;
  logic [CNT_W:0]    trial;
  logic              qbit;
  logic [CNT_W:0]    diff;

  always_comb begin
    trial = {rem, quotient[ACC_W-1]};
    qbit  = (trial >= {1'b0, den});
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        step     <= '0;
        rem      <= '0;
        den      <= divisor;
        quotient <= dividend;
      end else if (running) begin
        rem      <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quotient <= {quotient[ACC_W-2:0], qbit};
        if (step == STEP_W'(ACC_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/npc_back.sv -----
// back end: cell store, read-modify-write of one cell, composite result
// depends on npc_pkg and npc_div
module npc_back #(
  parameter int BANDS       = 4,
  parameter int TIME_SLOTS  = 4,
  parameter int TILE_PIXELS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [2:0]           mode,
  input  npc_pkg::item_t       head,
  input  logic                 head_valid,
  output logic                 pop,
  output logic                 clearing,
  output logic                 done,
  output logic [31:0]          composite_value,
  output logic                 composite_present,
  output logic [15:0]          contributions
);
  import npc_pkg::*;

  localparam int CELLS  = BANDS * TIME_SLOTS * TILE_PIXELS;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int WORD_W = ACC_W + CNT_W;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_DIV} state_t;

  state_t              state;
  item_t               cur;
  logic [ADDR_W-1:0]   addr;
  logic [ADDR_W-1:0]   clr_idx;
  logic [WORD_W-1:0]   mem [CELLS];
  logic [WORD_W-1:0]   rdata;
  logic                neg;

  logic                we;
  logic [ADDR_W-1:0]   wa;
  logic [WORD_W-1:0]   wd;

  logic [ACC_W-1:0]    rd_acc;
  logic [CNT_W-1:0]    rd_cnt;
  logic [ACC_W-1:0]    v48;
  logic [ACC_W-1:0]    new_acc;
  logic [CNT_W-1:0]    new_cnt;
  logic [ACC_W:0]      sum;
  logic                empty;
  logic [ACC_W-1:0]    rep_acc;
  logic [CNT_W-1:0]    rep_cnt;
  logic [ACC_W-1:0]    mag;
  logic                div_start;
  logic                div_done;
  logic [ACC_W-1:0]    quo;
  logic [ACC_W:0]      signed_quo;
  logic [31:0]         addr_full;

  function automatic logic [31:0] clamp32(input logic [ACC_W:0] x);
    if ($signed(x) > $signed({{(ACC_W-30){1'b0}}, 31'h7FFFFFFF})) begin
      return 32'h7FFFFFFF;
    end else if ($signed(x) < $signed({{(ACC_W-30){1'b1}}, 31'h0})) begin
      return 32'h80000000;
    end
    return x[31:0];
  endfunction

  // cell address of the queue head, latched when it is popped
  assign addr_full = (32'(head.band) * TIME_SLOTS + 32'(head.time_slot)) * TILE_PIXELS +
                     32'(head.pixel);

  always_comb begin
    rd_acc  = rdata[ACC_W-1:0];
    rd_cnt  = rdata[WORD_W-1:ACC_W];
    empty   = (rd_cnt == '0);
    v48     = {{(ACC_W-32){cur.pixel_value[31]}}, cur.pixel_value};
    sum     = {(empty ? 1'b0 : rd_acc[ACC_W-1]), (empty ? '0 : rd_acc)} +
              {v48[ACC_W-1], v48};
    new_acc = rd_acc;
    new_cnt = rd_cnt;
    if (mode == MODE_NONE || mode > MODE_MEAN) begin
      new_acc = cur.pixel_present ? v48 : '0;
      new_cnt = cur.pixel_present ? CNT_W'(1) : '0;
    end else if (cur.pixel_present) begin
      new_cnt = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
      unique case (mode)
        MODE_FIRST: if (empty) new_acc = v48;
        MODE_LAST:  new_acc = v48;
        MODE_MIN:   if (empty || $signed(v48) < $signed(rd_acc)) new_acc = v48;
        MODE_MAX:   if (empty || $signed(v48) > $signed(rd_acc)) new_acc = v48;
        default: begin
          // 48-bit saturating sum
          if (sum[ACC_W] != sum[ACC_W-1]) begin
            new_acc = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
          end else begin
            new_acc = sum[ACC_W-1:0];
          end
        end
      endcase
    end
    rep_acc = (cur.kind == KIND_READ) ? rd_acc : new_acc;
    rep_cnt = (cur.kind == KIND_READ) ? rd_cnt : new_cnt;
    mag     = rep_acc[ACC_W-1] ? (~rep_acc + 1'b1) : rep_acc;
    div_start = (state == S_EXEC) && cur.in_range && (rep_cnt != '0) &&
                (mode == MODE_MEAN);
    signed_quo = neg ? (~{1'b0, quo} + 1'b1) : {1'b0, quo};

    we = 1'b0;
    wa = addr;
    wd = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
      wa = clr_idx;
    end else if (state == S_EXEC && cur.in_range) begin
      we = 1'b1;
      wd = (cur.kind == KIND_READ) ? '0 : {new_cnt, new_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

  npc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (rep_cnt),
    .done     (div_done),
    .quotient (quo)
  );

  assign pop      = (state == S_IDLE) && head_valid;
  assign clearing = (state == S_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (32'(clr_idx) == CELLS - 1) state <= S_IDLE;
          else clr_idx <= clr_idx + 1'b1;
        end
        S_IDLE: begin
          if (head_valid) begin
            cur   <= head;
            addr  <= addr_full[ADDR_W-1:0];
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (div_start) begin
            neg               <= rep_acc[ACC_W-1];
            composite_present <= 1'b1;
            contributions     <= rep_cnt;
            state             <= S_DIV;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (!cur.in_range || rep_cnt == '0) begin
              composite_value   <= '0;
              composite_present <= 1'b0;
              contributions     <= '0;
            end else begin
              composite_value   <= clamp32({rep_acc[ACC_W-1], rep_acc});
              composite_present <= 1'b1;
              contributions     <= rep_cnt;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            composite_value <= clamp32(signed_quo);
            done            <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/nodata_aware_pixel_compositor_top.sv -----
// top level of the no-data aware pixel compositor: registers, front, back
// depends on npc_pkg, npc_front, npc_back, npc_div
//
// usage:
// - a transaction is taken at a clock edge with start high and busy low; it
//   names one cell by band, time_slot and pixel and either folds pixel_value
//   into it (kind fold) or reads the composite and empties it (kind read)
// - every transaction gives exactly one result: done is high for one cycle
//   with composite_value, composite_present and contributions; the receiver
//   cannot stall, so results are simply presented in order
// - for an idle block done follows the accepting edge through pop, cell
//   memory read, modify and write; in mean mode a cell that holds samples
//   also waits for the one-bit-per-cycle divider
// - a two-entry queue between front and back takes new transactions while the
//   back end works; busy rises when it is full; the back end finishes one
//   transaction before it pops the next, and mean composites take longer
// - after reset the cell store is swept to empty, one cell per cycle, all
//   BANDS*TIME_SLOTS*TILE_PIXELS cells (16384 by default); busy is high
//   meanwhile, register writes are taken as ever
// - registers on the apb port: mode at 0x0, pixels_per_image at 0x4,
//   times_per_chunk at 0x8; write them only while the block is idle
module nodata_aware_pixel_compositor_top #(
  parameter int BANDS       = 4,
  parameter int TIME_SLOTS  = 4,
  parameter int TILE_PIXELS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [1:0]  band,
  input  logic [1:0]  time_slot,
  input  logic [9:0]  pixel,
  input  logic [31:0] pixel_value,
  input  logic        pixel_present,
  output logic        done,
  output logic [31:0] composite_value,
  output logic        composite_present,
  output logic [15:0] contributions,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import npc_pkg::*;

  logic [2:0]  mode;
  logic [10:0] pixels_per_image;
  logic [2:0]  times_per_chunk;
  logic        accept;
  logic        pop;
  logic        full;
  logic        clearing;
  logic        head_valid;
  item_t       head;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_NONE;
      pixels_per_image <= 11'd1024;
      times_per_chunk  <= 3'd4;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_MODE:  mode             <= pwdata[2:0];
        REG_PPI:   pixels_per_image <= pwdata[10:0];
        REG_TIMES: times_per_chunk  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:  prdata = {29'd0, mode};
      REG_PPI:   prdata = {21'd0, pixels_per_image};
      REG_TIMES: prdata = {29'd0, times_per_chunk};
      default:   prdata = '0;
    endcase
  end

  // hold off new work while the store is swept or the queue is full
  assign busy   = clearing || full;
  assign accept = start && !busy;

  npc_front #(
    .BANDS       (BANDS),
    .TIME_SLOTS  (TIME_SLOTS),
    .TILE_PIXELS (TILE_PIXELS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .kind             (kind),
    .band             (band),
    .time_slot        (time_slot),
    .pixel            (pixel),
    .pixel_value      (pixel_value),
    .pixel_present    (pixel_present),
    .pixels_per_image (pixels_per_image),
    .times_per_chunk  (times_per_chunk),
    .pop              (pop),
    .head             (head),
    .head_valid       (head_valid),
    .full             (full)
  );

  npc_back #(
    .BANDS       (BANDS),
    .TIME_SLOTS  (TIME_SLOTS),
    .TILE_PIXELS (TILE_PIXELS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .mode              (mode),
    .head              (head),
    .head_valid        (head_valid),
    .pop               (pop),
    .clearing          (clearing),
    .done              (done),
    .composite_value   (composite_value),
    .composite_present (composite_present),
    .contributions     (contributions)
  );

endmodule

// ----- tb/npc_checker.sv -----
// result checker for the no-data aware pixel compositor: models the cell store
// and the registers, compares every done strobe; depends on npc_pkg
module npc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        kind,
  input  logic [1:0]  band,
  input  logic [1:0]  time_slot,
  input  logic [9:0]  pixel,
  input  logic [31:0] pixel_value,
  input  logic        pixel_present,
  input  logic        done,
  input  logic [31:0] composite_value,
  input  logic        composite_present,
  input  logic [15:0] contributions,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  import npc_pkg::*;

  localparam int CELLS = 4 * 4 * 1024;
  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -64'sh7FFF_FFFF_FFFF - 1;

  typedef struct {
    logic [31:0] value;
    logic        present;
    logic [15:0] count;
  } composite_t;

  longint      cell_sum [CELLS];
  logic [15:0] cell_cnt [CELLS];
  logic [2:0]  cfg_mode;
  logic [10:0] cfg_ppi;
  logic [2:0]  cfg_times;
  composite_t  expected_q[$];

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic composite_t fold_cell(logic k, logic [1:0] b, logic [1:0] ts,
                                           logic [9:0] p, logic [31:0] raw,
                                           logic pres);
    composite_t r;
    int a;
    longint v, s;
    logic empty;
    r = '{32'd0, 1'b0, 16'd0};
    if (ts >= cfg_times || p >= cfg_ppi) return r;
    a = (b * 4 + ts) * 1024 + p;
    v = longint'($signed(raw));
    empty = (cell_cnt[a] == 0);
    if (k == KIND_FOLD) begin
      if (cfg_mode == MODE_NONE || cfg_mode > MODE_MEAN) begin
        cell_sum[a] = pres ? v : 0;
        cell_cnt[a] = pres ? 16'd1 : 16'd0;
      end else if (pres) begin
        case (cfg_mode)
          MODE_FIRST: if (empty) cell_sum[a] = v;
          MODE_LAST:  cell_sum[a] = v;
          MODE_MIN:   if (empty || v < cell_sum[a]) cell_sum[a] = v;
          MODE_MAX:   if (empty || v > cell_sum[a]) cell_sum[a] = v;
          default: begin
            s = (empty ? 0 : cell_sum[a]) + v;
            cell_sum[a] = s > SUM_MAX ? SUM_MAX : (s < SUM_MIN ? SUM_MIN : s);
          end
        endcase
        if (cell_cnt[a] != 16'hFFFF) cell_cnt[a] = cell_cnt[a] + 16'd1;
      end
    end
    if (cell_cnt[a] != 0) begin
      // mean divides with truncation toward zero, as sv integer division does
      if (cfg_mode == MODE_MEAN)
        r.value = 32'(sat32(cell_sum[a] / longint'({48'd0, cell_cnt[a]})));
      else
        r.value = 32'(sat32(cell_sum[a]));
    end
    r.present = cell_cnt[a] != 0;
    r.count   = cell_cnt[a];
    if (k == KIND_READ) begin
      cell_sum[a] = 0;
      cell_cnt[a] = 0;
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    composite_t e;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        cell_sum[i] = 0;
        cell_cnt[i] = 0;
      end
      cfg_mode  = MODE_NONE;
      cfg_ppi   = 11'd1024;
      cfg_times = 3'd4;
      expected_q.delete();
      errors = 0;
    end else begin
      // results first: a result never belongs to a transaction of this edge
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result with no transaction outstanding");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (composite_value !== e.value) begin
            $error("composite_value expected %h got %h", e.value, composite_value);
            errors++;
          end
          if (composite_present !== e.present) begin
            $error("composite_present expected %b got %b", e.present, composite_present);
            errors++;
          end
          if (contributions !== e.count) begin
            $error("contributions expected %0d got %0d", e.count, contributions);
            errors++;
          end
        end
      end
      if (start && !busy)
        expected_q.insert(expected_q.size(),
                          fold_cell(kind, band, time_slot, pixel, pixel_value,
                                    pixel_present));
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MODE:  cfg_mode  = pwdata[2:0];
          REG_PPI:   cfg_ppi   = pwdata[10:0];
          REG_TIMES: cfg_times = pwdata[2:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- tb/tb_nodata_aware_pixel_compositor_top.sv -----
// testbench top for the no-data aware pixel compositor: clock, reset, apb
// writes and transaction stimulus; depends on npc_pkg, npc_checker and the rtl
module tb_nodata_aware_pixel_compositor_top;
  import npc_pkg::*;

  localparam int STALL_LIMIT = 40000;  // covers the clearing sweep of all 16384 cells

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        kind = 1'b0;
  logic [1:0]  band = '0;
  logic [1:0]  time_slot = '0;
  logic [9:0]  pixel = '0;
  logic [31:0] pixel_value = '0;
  logic        pixel_present = 1'b0;
  logic        done;
  logic [31:0] composite_value;
  logic        composite_present;
  logic [15:0] contributions;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          quiet_cycles;
  logic        calm;  // no idle gaps in the last stretch

  always #4 clk = ~clk;

  nodata_aware_pixel_compositor_top dut (.*);

  npc_checker chk (.*);

  // watchdog: cycles in which no transaction and no result moved
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // apb write: setup phase, then access phase
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // present one transaction and hold it until busy is low at an edge
  task automatic send_pixel(logic k, logic [1:0] b, logic [1:0] ts, logic [9:0] p,
                            logic [31:0] v, logic pres);
    int gap;
    if (!calm && $urandom_range(3) == 0) begin
      gap = $urandom_range(3, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    kind          <= k;
    band          <= b;
    time_slot     <= ts;
    pixel         <= p;
    pixel_value   <= v;
    pixel_present <= pres;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);  // mean divider tail
  endtask

  // random cell inside a small window so cells get revisited
  task automatic random_item(int ppi, int times);
    logic [9:0]  p;
    logic [31:0] v;
    int pick;
    p = (ppi > 0 && $urandom_range(15) != 0) ? 10'($urandom_range(ppi - 1) % 8)
                                            : 10'($urandom);
    pick = $urandom_range(9);
    case (pick)
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      default: v = $urandom;
    endcase
    send_pixel($urandom_range(5) == 0 ? KIND_READ : KIND_FOLD, 2'($urandom),
               (times > 0 && $urandom_range(7) != 0) ? 2'($urandom_range(times - 1) % 4)
                                                    : 2'($urandom),
               p, v, $urandom_range(4) != 0);
  endtask

  initial begin
    int modes[8] = '{MODE_NONE, MODE_FIRST, MODE_LAST, MODE_MIN, MODE_MAX,
                     MODE_MEAN, 6, 7};
    int ppi, times;
    calm = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every mode, no-data, out of range cells, clears
    foreach (modes[m]) begin
      write_reg(REG_MODE, modes[m]);
      send_pixel(KIND_FOLD, 2'd3, 2'd3, 10'd1023, 32'h7FFF_FFFF, 1'b1);
      send_pixel(KIND_FOLD, 2'd3, 2'd3, 10'd1023, 32'h8000_0000, 1'b1);
      send_pixel(KIND_FOLD, 2'd3, 2'd3, 10'd1023, 32'h1234_5678, 1'b0);
      send_pixel(KIND_READ, 2'd3, 2'd3, 10'd1023, 32'h0, 1'b0);
      send_pixel(KIND_READ, 2'd0, 2'd0, 10'd0, 32'hFFFF_FFFF, 1'b1);
      drain();
    end
    write_reg(REG_PPI, 32'd0);
    send_pixel(KIND_FOLD, 2'd0, 2'd0, 10'd0, 32'd5, 1'b1);
    drain();
    write_reg(REG_PPI, 32'd1);
    write_reg(REG_TIMES, 32'd1);
    send_pixel(KIND_FOLD, 2'd0, 2'd0, 10'd1, 32'd5, 1'b1);
    send_pixel(KIND_FOLD, 2'd1, 2'd1, 10'd0, 32'd5, 1'b1);
    send_pixel(KIND_FOLD, 2'd2, 2'd0, 10'd0, 32'd7, 1'b1);
    drain();

    // random phases across register settings, extremes included
    for (int ph = 0; ph < 16; ph++) begin
      ppi   = (ph == 0) ? 1024 : (ph == 1) ? 1 : (ph == 2) ? 0 : $urandom_range(1024, 1);
      times = (ph == 3) ? 0 : (ph == 4) ? 7 : $urandom_range(4, 1);
      write_reg(REG_MODE, (ph % 4 == 0) ? MODE_MEAN : $urandom_range(7));
      write_reg(REG_PPI, ppi);
      write_reg(REG_TIMES, times);
      if (ph == 15) calm = 1'b1;
      for (int i = 0; i < 120; i++) random_item(ppi, times);
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
